// File: rtl/grid_cell_neighbor_counter_unit_defines.svh
// ---------------------------------------------------------------------------
// Grid cell neighbor counter: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_NEIGHBOR_COUNTER_UNIT_DEFINES_SVH
`define GRID_CELL_NEIGHBOR_COUNTER_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define GCNC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define GCNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/gcnc_pkg.sv
// ---------------------------------------------------------------------------
// gcnc_pkg
// Constants, codes and controller/datapath interface types of the grid cell
// neighbor counter.
// ---------------------------------------------------------------------------
`default_nettype none

package gcnc_pkg;

	// Sizing of the stores and the fixed-point format
	localparam int MAX_NODES  = 1024;
	localparam int GRID_MAX   = 64;
	localparam int FRAC_BITS  = 16;
	localparam int CELL_DEPTH = (GRID_MAX + 2) * (GRID_MAX + 2);
	localparam int GRID_RESET = 8;

	// Field widths
	localparam int CMD_W   = 2;
	localparam int POS_W   = FRAC_BITS + 1;
	localparam int GRID_W  = 7;
	localparam int ID_W    = 10;
	localparam int CELL_W  = 13;
	localparam int NCNT_W  = 10;
	localparam int STAT_W  = 2;

	// Internal widths
	localparam int SIDE_W    = $clog2(GRID_MAX + 3);
	localparam int COORD_W   = $clog2(GRID_MAX + 1);
	localparam int PROD_W    = POS_W + GRID_W;
	localparam int IDXP_W    = SIDE_W + COORD_W + 1;
	localparam int NODES_W   = $clog2(MAX_NODES + 1);
	localparam int NADDR_W   = $clog2(MAX_NODES);
	localparam int CCNT_W    = 11;
	localparam int NBR_SPAN  = 3;
	localparam int NBR_TAPS  = NBR_SPAN * NBR_SPAN;
	localparam int NBR_W     = $clog2(NBR_TAPS + 1);
	localparam int COL_W     = $clog2(NBR_SPAN);
	localparam int SUM_W     = CCNT_W + NBR_W;
	localparam int DIV_CNT_W = $clog2(CELL_W);

	// Stream and register port widths
	localparam int S_TDATA_W = ((2 * POS_W + ID_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ID_W + CELL_W + NCNT_W + 7) / 8) * 8;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = APB_AW - 2;

	localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = REG_IDX_W'(0);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_NOT_LOADED = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_FULL,
		RES_ADD,
		RES_QERR,
		RES_QRY
	} res_sel_t;

	typedef enum logic [3:0] {
		S_INIT_CLR,
		S_IDLE,
		S_DEC,
		S_CLR,
		S_A_MUL,
		S_A_IDX,
		S_A_RD,
		S_A_WR,
		S_Q_LOAD,
		S_Q_DIV,
		S_Q_CHK,
		S_Q_SUM,
		S_Q_FIN,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     in_load;
		logic     clr_step;
		logic     nodes_clr;
		logic     add_mul;
		logic     add_idx;
		logic     add_rd;
		logic     add_wr;
		logic     div_start;
		logic     sum_start;
		logic     sum_step;
		logic     res_set;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		cmd_t op;
		logic full;
		logic id_bad;
		logic div_done;
		logic in_grid;
		logic sum_last;
		logic clr_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/gcnc_ram.sv
// ---------------------------------------------------------------------------
// gcnc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gcnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/gcnc_div.sv
// ---------------------------------------------------------------------------
// gcnc_div
// Restoring divider, one quotient bit per cycle: splits a linear cell index
// into row (quotient) and column (remainder) for a given grid side.
// ---------------------------------------------------------------------------
`default_nettype none

module gcnc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gcnc_pkg::CELL_W-1:0] dividend,
	input  logic [gcnc_pkg::SIDE_W-1:0] divisor,
	output logic                        busy,
	output logic                        last,
	output logic [gcnc_pkg::CELL_W-1:0] quo,
	output logic [gcnc_pkg::SIDE_W-1:0] rem
);
	import gcnc_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CELL_W-1:0]    quo_q;
	logic [SIDE_W-1:0]    rem_q;
	logic [SIDE_W:0]      trial;
	logic [SIDE_W+1:0]    diff;

	// Shift in the next dividend bit and try to subtract
	always_comb begin
		trial = {rem_q, quo_q[CELL_W-1]};
		diff  = {1'b0, trial} - (SIDE_W + 2)'(divisor);
	end

	assign last = busy_q && (cnt_q == DIV_CNT_W'(CELL_W - 1));

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[SIDE_W+1]) begin
				rem_q <= diff[SIDE_W-1:0];
				quo_q <= {quo_q[CELL_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SIDE_W-1:0];
				quo_q <= {quo_q[CELL_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/gcnc_dp.sv
// ---------------------------------------------------------------------------
// gcnc_dp
// Datapath: input latch, binning multipliers, cell count and node cell RAMs,
// index divider, 3x3 accumulator, result staging and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_cell_neighbor_counter_unit_defines.svh"

module gcnc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gcnc_pkg::GRID_W-1:0] grid_size,
	input  logic [gcnc_pkg::CMD_W-1:0]  in_cmd,
	input  logic [gcnc_pkg::POS_W-1:0]  in_pos_x,
	input  logic [gcnc_pkg::POS_W-1:0]  in_pos_y,
	input  logic [gcnc_pkg::ID_W-1:0]   in_node_id,
	input  gcnc_pkg::ctrl_cmd_t         cmd,
	output gcnc_pkg::ctrl_sts_t         sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [gcnc_pkg::ID_W-1:0]   out_assigned_id,
	output logic [gcnc_pkg::CELL_W-1:0] out_cell_index,
	output logic [gcnc_pkg::NCNT_W-1:0] out_neighbor_count,
	output logic [gcnc_pkg::STAT_W-1:0] out_status
);
	import gcnc_pkg::*;

	localparam logic [CCNT_W-1:0] CCNT_MAX = '1;
	localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1) << FRAC_BITS;

	// Input latch
	cmd_t             op_q;
	logic [POS_W-1:0] px_q;
	logic [POS_W-1:0] py_q;
	logic [ID_W-1:0]  nid_q;

	// Grid geometry
	logic [GRID_W-1:0] g_eff;
	logic [SIDE_W-1:0] side;

	// Binning
	logic [POS_W-1:0]   px_sat;
	logic [POS_W-1:0]   py_sat;
	logic [PROD_W-1:0]  prod_x;
	logic [PROD_W-1:0]  prod_y;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [COORD_W:0]   cx1;
	logic [COORD_W:0]   cy1;
	logic [IDXP_W-1:0]  idx_prod;
	logic [CELL_W-1:0]  idx_calc;
	logic [CELL_W-1:0]  idx_q;

	// Stores
	logic [NODES_W-1:0] nodes_q;
	logic [CELL_W-1:0]  clr_q;
	logic               cell_we;
	logic [CELL_W-1:0]  cell_waddr;
	logic [CCNT_W-1:0]  cell_wdata;
	logic [CELL_W-1:0]  cell_raddr;
	logic [CCNT_W-1:0]  cell_rdata;
	logic [CCNT_W-1:0]  cell_inc;
	logic [CELL_W-1:0]  node_rdata;

	// Divider
	logic              div_busy;
	logic              div_last;
	logic [CELL_W-1:0] div_quo;
	logic [SIDE_W-1:0] div_rem;

	// Neighborhood sum
	logic [CELL_W-1:0] base;
	logic [CELL_W-1:0] row_q;
	logic [COL_W-1:0]  col_q;
	logic [NBR_W-1:0]  k_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_dec;
	logic [NCNT_W-1:0] cnt_cap;

	// Result staging and output register
	logic [ID_W-1:0]   res_id_q;
	logic [CELL_W-1:0] res_cell_q;
	logic [NCNT_W-1:0] res_cnt_q;
	stat_t             res_stat_q;
	logic              out_valid_q;

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q  <= cmd_t'(in_cmd);
			px_q  <= in_pos_x;
			py_q  <= in_pos_y;
			nid_q <= in_node_id;
		end
	end

	// Clamp the grid size and derive the bordered side
	always_comb begin
		if (grid_size == '0) begin
			g_eff = GRID_W'(1);
		end else if (grid_size > GRID_W'(GRID_MAX)) begin
			g_eff = GRID_W'(GRID_MAX);
		end else begin
			g_eff = grid_size;
		end
		side = SIDE_W'(g_eff) + SIDE_W'(2);
	end

	// Saturate positions to 1.0 and scale by the grid size
	always_comb begin
		px_sat = px_q[FRAC_BITS] ? POS_ONE : px_q;
		py_sat = py_q[FRAC_BITS] ? POS_ONE : py_q;
		prod_x = PROD_W'(px_sat) * PROD_W'(g_eff);
		prod_y = PROD_W'(py_sat) * PROD_W'(g_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.add_mul) begin
			cx_q <= prod_x[FRAC_BITS +: COORD_W];
			cy_q <= prod_y[FRAC_BITS +: COORD_W];
		end
	end

	// Linear cell index with the border offset
	always_comb begin
		cx1      = {1'b0, cx_q} + (COORD_W + 1)'(1);
		cy1      = {1'b0, cy_q} + (COORD_W + 1)'(1);
		idx_prod = IDXP_W'(side) * IDXP_W'(cx1);
		idx_calc = CELL_W'(idx_prod + IDXP_W'(cy1));
	end

	always_ff @(posedge clk) begin
		if (cmd.add_idx) begin
			idx_q <= idx_calc;
		end else if (cmd.div_start) begin
			idx_q <= node_rdata;
		end
	end

	// Node count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= '0;
		end else if (cmd.nodes_clr) begin
			nodes_q <= '0;
		end else if (cmd.add_wr) begin
			nodes_q <= nodes_q + NODES_W'(1);
		end
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= sts.clr_last ? '0 : clr_q + CELL_W'(1);
		end
	end

	// Cell count RAM port selection
	always_comb begin
		cell_inc   = (cell_rdata == CCNT_MAX) ? cell_rdata : cell_rdata + CCNT_W'(1);
		cell_we    = cmd.clr_step | cmd.add_wr;
		cell_waddr = cmd.clr_step ? clr_q : idx_q;
		cell_wdata = cmd.clr_step ? '0 : cell_inc;
		cell_raddr = cmd.add_rd ? idx_q : row_q + CELL_W'(col_q);
	end

	gcnc_ram #(
		.WIDTH (CCNT_W),
		.DEPTH (CELL_DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	gcnc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (cmd.add_wr),
		.waddr (nodes_q[NADDR_W-1:0]),
		.wdata (idx_q),
		.raddr (nid_q),
		.rdata (node_rdata)
	);

	// Split the stored index into row and column
	gcnc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (node_rdata),
		.divisor  (side),
		.busy     (div_busy),
		.last     (div_last),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Walk the 3x3 block: read one cell a cycle, add the previous read
	assign base = idx_q - CELL_W'(side) - CELL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			col_q <= '0;
		end else if (cmd.sum_start) begin
			k_q   <= '0;
			col_q <= '0;
		end else if (cmd.sum_step) begin
			k_q <= k_q + NBR_W'(1);
			if (k_q != NBR_W'(NBR_TAPS)) begin
				col_q <= (col_q == COL_W'(NBR_SPAN - 1)) ? '0 : col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			row_q <= base;
			sum_q <= '0;
		end else if (cmd.sum_step) begin
			if (k_q != NBR_W'(NBR_TAPS) && col_q == COL_W'(NBR_SPAN - 1)) begin
				row_q <= row_q + CELL_W'(side);
			end
			if (k_q != '0) begin
				sum_q <= sum_q + SUM_W'(cell_rdata);
			end
		end
	end

	// Drop the node itself and cap the count
	always_comb begin
		sum_dec = sum_q - SUM_W'(1);
		if (sum_q == '0) begin
			cnt_cap = '0;
		end else if (sum_dec > SUM_W'({NCNT_W{1'b1}})) begin
			cnt_cap = '1;
		end else begin
			cnt_cap = sum_dec[NCNT_W-1:0];
		end
	end

	// Stage the result of the finished item
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			case (cmd.res_sel)
				RES_FULL: begin
					res_id_q   <= '0;
					res_cell_q <= '0;
					res_cnt_q  <= '0;
					res_stat_q <= STAT_FULL;
				end
				RES_ADD: begin
					res_id_q   <= nodes_q[ID_W-1:0];
					res_cell_q <= idx_q;
					res_cnt_q  <= '0;
					res_stat_q <= STAT_OK;
				end
				RES_QERR: begin
					res_id_q   <= nid_q;
					res_cell_q <= '0;
					res_cnt_q  <= '0;
					res_stat_q <= STAT_NOT_LOADED;
				end
				RES_QRY: begin
					res_id_q   <= nid_q;
					res_cell_q <= idx_q;
					res_cnt_q  <= cnt_cap;
					res_stat_q <= STAT_OK;
				end
				default: begin
					res_id_q   <= '0;
					res_cell_q <= '0;
					res_cnt_q  <= '0;
					res_stat_q <= STAT_OK;
				end
			endcase
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_assigned_id    <= res_id_q;
			out_cell_index     <= res_cell_q;
			out_neighbor_count <= res_cnt_q;
			out_status         <= res_stat_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller
	always_comb begin
		sts.op       = op_q;
		sts.full     = nodes_q >= NODES_W'(MAX_NODES);
		sts.id_bad   = NODES_W'(nid_q) >= nodes_q;
		sts.div_done = div_last;
		sts.in_grid  = (div_quo != '0) && (div_quo <= CELL_W'(g_eff)) &&
			(div_rem != '0) && (div_rem <= SIDE_W'(g_eff));
		sts.sum_last = k_q == NBR_W'(NBR_TAPS);
		sts.clr_last = clr_q == CELL_W'(CELL_DEPTH - 1);
		sts.out_free = !out_valid_q || out_ready;
	end

	`GCNC_ASSERT_NOW(a_nodes_bound, 1'b1, nodes_q <= NODES_W'(MAX_NODES), "node count above capacity")
	`GCNC_ASSERT_NOW(a_cell_waddr, cell_we, cell_waddr < CELL_W'(CELL_DEPTH), "cell write out of range")
	`GCNC_ASSERT_NOW(a_sum_raddr, cmd.sum_step && (k_q != NBR_W'(NBR_TAPS)), cell_raddr < CELL_W'(CELL_DEPTH), "neighbor read out of range")
	`GCNC_ASSERT_NOW(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
	`GCNC_ASSERT_NEXT(a_add_count, cmd.add_wr, nodes_q == $past(nodes_q) + NODES_W'(1), "add did not advance node count")

endmodule

`default_nettype wire

// File: rtl/gcnc_ctrl.sv
// ---------------------------------------------------------------------------
// gcnc_ctrl
// Controller: sequences the clearing sweep, add, query and clear items and
// hands each result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gcnc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gcnc_pkg::ctrl_sts_t sts,
	output gcnc_pkg::ctrl_cmd_t cmd
);
	import gcnc_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register: reset starts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT_CLR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.op)
					CMD_ADD:   state_d = sts.full ? S_FIN : S_A_MUL;
					CMD_QUERY: state_d = sts.id_bad ? S_FIN : S_Q_LOAD;
					CMD_CLEAR: state_d = S_CLR;
					default:   state_d = S_FIN;
				endcase
			end
			S_CLR: begin
				if (sts.clr_last) begin
					state_d = S_FIN;
				end
			end
			S_A_MUL:  state_d = S_A_IDX;
			S_A_IDX:  state_d = S_A_RD;
			S_A_RD:   state_d = S_A_WR;
			S_A_WR:   state_d = S_FIN;
			S_Q_LOAD: state_d = S_Q_DIV;
			S_Q_DIV: begin
				if (sts.div_done) begin
					state_d = S_Q_CHK;
				end
			end
			S_Q_CHK: begin
				state_d = sts.in_grid ? S_Q_SUM : S_Q_FIN;
			end
			S_Q_SUM: begin
				if (sts.sum_last) begin
					state_d = S_Q_FIN;
				end
			end
			S_Q_FIN: state_d = S_FIN;
			S_FIN: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_ZERO;
		in_ready    = 1'b0;
		case (state_q)
			S_INIT_CLR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			S_DEC: begin
				case (sts.op)
					CMD_ADD: begin
						cmd.res_set = sts.full;
						cmd.res_sel = RES_FULL;
					end
					CMD_QUERY: begin
						cmd.res_set = sts.id_bad;
						cmd.res_sel = RES_QERR;
					end
					CMD_CLEAR: begin
						cmd.nodes_clr = 1'b1;
					end
					default: begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_ZERO;
					end
				endcase
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				cmd.res_set  = sts.clr_last;
				cmd.res_sel  = RES_ZERO;
			end
			S_A_MUL: begin
				cmd.add_mul = 1'b1;
			end
			S_A_IDX: begin
				cmd.add_idx = 1'b1;
			end
			S_A_RD: begin
				cmd.add_rd = 1'b1;
			end
			S_A_WR: begin
				cmd.add_wr  = 1'b1;
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_ADD;
			end
			S_Q_LOAD: begin
				cmd.div_start = 1'b1;
			end
			S_Q_CHK: begin
				cmd.sum_start = 1'b1;
			end
			S_Q_SUM: begin
				cmd.sum_step = 1'b1;
			end
			S_Q_FIN: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_QRY;
			end
			S_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd.res_sel = RES_ZERO;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/grid_cell_neighbor_counter_unit.sv
// ---------------------------------------------------------------------------
// grid_cell_neighbor_counter_unit
// Bins nodes into a bordered square grid of cells and answers how many other
// nodes lie in the 3x3 cells around a loaded node.
// Items enter on the s_axis stream (tuser = command), one result per item
// leaves on the m_axis stream (tuser = status). The user must set grid_size over
// APB only while the block is idle; the block itself does not enforce it.
// The next item is taken in the cycle after the result is loaded. A query is
// bounded by the 13-step index divider and by nine reads of the single read
// port of the cell count RAM; a clear by the sweep over its 4356 entries.
// After reset the block sweeps all 4356 entries of the cell count RAM with
// s_axis_tready low; APB writes are taken throughout.
// A finished result waits in the output register while m_axis_tready is low;
// the next item is accepted meanwhile and then stalls at its own result.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_cell_neighbor_counter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gcnc_pkg::APB_AW-1:0]    paddr,
	input  logic [gcnc_pkg::APB_DW-1:0]    pwdata,
	output logic [gcnc_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	// Item stream in
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pos_x[16:0], pos_y[33:17], node_id[43:34], zero pad
	input  logic [gcnc_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [gcnc_pkg::CMD_W-1:0]     s_axis_tuser,
	// Result stream out
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// assigned_id[9:0], cell_index[22:10], neighbor_count[32:23], zero pad
	output logic [gcnc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [gcnc_pkg::STAT_W-1:0]    m_axis_tuser
);
	import gcnc_pkg::*;

	logic [GRID_W-1:0]    grid_size_q;
	logic [REG_IDX_W-1:0] reg_idx;
	ctrl_cmd_t            cmd;
	ctrl_sts_t            sts;
	logic [ID_W-1:0]      out_id;
	logic [CELL_W-1:0]    out_cell;
	logic [NCNT_W-1:0]    out_cnt;

	// Register file
	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_W'(GRID_RESET);
		end else if (psel && penable && pwrite && pready && reg_idx == REG_GRID_SIZE) begin
			grid_size_q <= pwdata[GRID_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_GRID_SIZE) ? APB_DW'(grid_size_q) : '0;

	gcnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcnc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.grid_size          (grid_size_q),
		.in_cmd             (s_axis_tuser),
		.in_pos_x           (s_axis_tdata[POS_W-1:0]),
		.in_pos_y           (s_axis_tdata[2*POS_W-1:POS_W]),
		.in_node_id         (s_axis_tdata[2*POS_W+ID_W-1:2*POS_W]),
		.cmd                (cmd),
		.sts                (sts),
		.out_ready          (m_axis_tready),
		.out_valid          (m_axis_tvalid),
		.out_assigned_id    (out_id),
		.out_cell_index     (out_cell),
		.out_neighbor_count (out_cnt),
		.out_status         (m_axis_tuser)
	);

	// Pack the result fields, first field lowest
	assign m_axis_tdata = M_TDATA_W'({out_cnt, out_cell, out_id});

endmodule

`default_nettype wire

// File: tb/sv/tb_grid_cell_neighbor_counter_unit.sv
// ---------------------------------------------------------------------------
// tb_grid_cell_neighbor_counter_unit
// Self-checking bench for the grid cell neighbor counter. A small scoreboard
// keeps its own cell counters and node table. It predicts the one result of
// every accepted item and compares each result transfer with the oldest
// prediction, field by field. A directed opening covers the position and id
// extremes, every command, the border cell and queries of unloaded ids.
// Random phases then sweep the grid size, including 0, 1, 64 and a value above
// the top of the range. Some phases leave nodes loaded across a size change,
// and the last phase fills the node store past capacity. Both streams idle in
// short random bursts, and the end of the run has no idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_grid_cell_neighbor_counter_unit;
	import gcnc_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int REPORT_MAX = 10;
	localparam int POS_ONE    = 1 << FRAC_BITS;

	typedef struct packed {
		cmd_t              cmd;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [ID_W-1:0]   node_id;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   assigned_id;
		logic [CELL_W-1:0] cell_index;
		logic [NCNT_W-1:0] neighbor_count;
		stat_t             status;
	} result_t;

	// Scoreboard: binning state of the block and the results still awaited
	class cell_bin_tracker;
		logic [GRID_W-1:0] grid_size;
		int unsigned       cell_count [CELL_DEPTH];
		int unsigned       node_cell [MAX_NODES];
		int unsigned       nodes_loaded;
		result_t           awaited [$];
		int unsigned       mismatches;

		function new();
			grid_size = GRID_W'(GRID_RESET);
			foreach (cell_count[i]) cell_count[i] = 0;
			foreach (node_cell[i]) node_cell[i] = 0;
			nodes_loaded = 0;
			mismatches = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		// Clamp the register to the supported grid range
		function int unsigned grid_cells();
			int unsigned g;
			g = grid_size;
			if (g == 0) g = 1;
			if (g > GRID_MAX) g = GRID_MAX;
			return g;
		endfunction

		// Truncate position times grid size, saturating the position at 1.0
		function int unsigned to_cell(logic [POS_W-1:0] pos, int unsigned g);
			int unsigned p;
			p = pos;
			if (p > POS_ONE) p = POS_ONE;
			return (p * g) >> FRAC_BITS;
		endfunction

		// Note an accepted item and queue the result it must produce
		function void note_item(item_t it);
			result_t     res;
			int unsigned g, side, idx, xs, ys, sum, addr, a, b;
			g = grid_cells();
			side = g + 2;
			res = '0;
			case (it.cmd)
				CMD_ADD: begin
					if (nodes_loaded >= MAX_NODES) begin
						res.status = STAT_FULL;
					end else begin
						idx = side * (to_cell(it.pos_x, g) + 1) + to_cell(it.pos_y, g) + 1;
						if (idx < CELL_DEPTH && cell_count[idx] < (1 << CCNT_W) - 1)
							cell_count[idx]++;
						node_cell[nodes_loaded] = idx % (1 << CELL_W);
						res.assigned_id = ID_W'(nodes_loaded);
						res.cell_index = CELL_W'(idx);
						nodes_loaded++;
					end
				end
				CMD_QUERY: begin
					res.assigned_id = it.node_id;
					if (it.node_id >= nodes_loaded) begin
						res.status = STAT_NOT_LOADED;
					end else begin
						// Decode the stored index with the grid size in force now
						idx = node_cell[it.node_id];
						xs = idx / side;
						ys = idx % side;
						res.cell_index = CELL_W'(idx);
						if (xs >= 1 && xs <= g && ys >= 1 && ys <= g) begin
							sum = 0;
							for (a = xs - 1; a <= xs + 1; a++)
								for (b = ys - 1; b <= ys + 1; b++) begin
									addr = side * a + b;
									if (addr < CELL_DEPTH) sum += cell_count[addr];
								end
							if (sum > 0) sum--;
							if (sum > (1 << NCNT_W) - 1) sum = (1 << NCNT_W) - 1;
							res.neighbor_count = NCNT_W'(sum);
						end
					end
				end
				CMD_CLEAR: begin
					foreach (cell_count[i]) cell_count[i] = 0;
					nodes_loaded = 0;
				end
				default: begin
				end
			endcase
			awaited = {awaited, res};
		endfunction

		// Compare one result transfer with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected result id %0d cell %0d count %0d status %0d",
					got.assigned_id, got.cell_index, got.neighbor_count, got.status));
				return;
			end
			want = awaited.pop_front();
			if (got.assigned_id !== want.assigned_id || got.cell_index !== want.cell_index ||
					got.neighbor_count !== want.neighbor_count || got.status !== want.status)
				flag($sformatf({"expected id %0d cell %0d count %0d status %0d, ",
					"got id %0d cell %0d count %0d status %0d"},
					want.assigned_id, want.cell_index, want.neighbor_count, want.status,
					got.assigned_id, got.cell_index, got.neighbor_count, got.status));
		endfunction

		// Fail every prediction that never saw its result
		function void close();
			result_t want;
			while (awaited.size() != 0) begin
				want = awaited.pop_front();
				flag($sformatf("missing result id %0d cell %0d count %0d status %0d",
					want.assigned_id, want.cell_index, want.neighbor_count, want.status));
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_AW-1:0]     paddr         = '0;
	logic [APB_DW-1:0]     pwdata        = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [CMD_W-1:0]      s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [STAT_W-1:0]     m_axis_tuser;

	cell_bin_tracker       tracker = new();
	bit                    calm = 1'b0;
	int unsigned           stall_left = 0;
	int unsigned           idle_cycles = 0;
	logic [POS_W-1:0]      last_x = '0;
	logic [POS_W-1:0]      last_y = '0;

	grid_cell_neighbor_counter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the result stream in short random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(result_t'{
				assigned_id:    m_axis_tdata[ID_W-1:0],
				cell_index:     m_axis_tdata[ID_W+CELL_W-1:ID_W],
				neighbor_count: m_axis_tdata[ID_W+CELL_W+NCNT_W-1:ID_W+CELL_W],
				status:         stat_t'(m_axis_tuser)});
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item, note it on transfer, then maybe leave a gap
	task automatic send_item(item_t it);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_TDATA_W'({it.node_id, it.pos_y, it.pos_x});
		s_axis_tuser  <= it.cmd;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_item(it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic put(cmd_t c, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
			logic [ID_W-1:0] nid);
		send_item(item_t'{cmd: c, pos_x: px, pos_y: py, node_id: nid});
	endtask

	// Hold the input until every awaited result has arrived
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic write_grid(int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({REG_GRID_SIZE, 2'b00});
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		tracker.grid_size = GRID_W'(value);
	endtask

	// Position mix: edges, beyond 1.0, clusters near the last node, uniform
	function automatic logic [POS_W-1:0] pick_pos(logic [POS_W-1:0] near);
		int p;
		case ($urandom_range(0, 9))
			0: return POS_W'(POS_ONE);
			1: return POS_W'($urandom_range(POS_ONE + 1, (1 << POS_W) - 1));
			2: return $urandom_range(0, 1) ? POS_W'(POS_ONE - 1) : '0;
			3, 4, 5: begin
				p = int'(near) + int'($urandom_range(0, 4000)) - 2000;
				if (p < 0) p = 0;
				if (p > POS_ONE - 1) p = POS_ONE - 1;
				return POS_W'(p);
			end
			default: return POS_W'($urandom_range(0, POS_ONE - 1));
		endcase
	endfunction

	// Mostly adds and queries of loaded ids; filling drops clears
	function automatic item_t random_item(bit filling);
		item_t       it;
		int unsigned r;
		it.pos_x   = POS_W'($urandom);
		it.pos_y   = POS_W'($urandom);
		it.node_id = ID_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < (filling ? 90 : 48)) begin
			it.cmd   = CMD_ADD;
			it.pos_x = pick_pos(last_x);
			it.pos_y = pick_pos(last_y);
			last_x   = it.pos_x;
			last_y   = it.pos_y;
		end else if (r < (filling ? 98 : 90)) begin
			it.cmd = CMD_QUERY;
			if (tracker.nodes_loaded != 0 && $urandom_range(0, 4) != 0)
				it.node_id = ID_W'($urandom_range(0, tracker.nodes_loaded - 1));
		end else if (r < (filling ? 100 : 97)) begin
			it.cmd = CMD_NOP;
		end else begin
			it.cmd = CMD_CLEAR;
		end
		return it;
	endfunction

	task automatic run_phase(int unsigned grid, int unsigned count);
		int unsigned k;
		drain();
		write_grid(grid);
		for (k = 0; k < count; k++) begin
			if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
			send_item(random_item(1'b0));
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned extra;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset grid size
		put(CMD_QUERY, '0, '0, '0);
		put(CMD_QUERY, 17'h1FFFF, 17'h1FFFF, 10'd1023);
		put(CMD_NOP, 17'h15555, 17'h0AAAA, 10'h2AA);
		put(CMD_ADD, '0, '0, 10'd1023);
		put(CMD_ADD, 17'd65535, 17'd65535, '0);
		put(CMD_ADD, 17'd65536, 17'd65536, '0);
		put(CMD_ADD, 17'h1FFFF, '0, '0);
		put(CMD_ADD, '0, 17'd65536, '0);
		put(CMD_ADD, 17'd32768, 17'd32768, '0);
		put(CMD_ADD, 17'd32768, 17'd40000, '0);
		put(CMD_ADD, 17'd30000, 17'd32768, '0);
		for (k = 0; k < 8; k++)
			put(CMD_QUERY, '0, '0, ID_W'(k));
		put(CMD_QUERY, '0, '0, 10'd8);
		put(CMD_CLEAR, 17'h0AAAA, 17'h15555, 10'h155);
		put(CMD_QUERY, '0, '0, '0);
		put(CMD_ADD, 17'h0AAAA, 17'h15555, 10'h155);
		put(CMD_QUERY, '0, '0, '0);

		// Random phases across grid sizes; later ones reuse loaded nodes
		run_phase(1, 100);
		run_phase(GRID_MAX, 100);
		run_phase(0, 60);
		run_phase((1 << GRID_W) - 1, 80);
		run_phase($urandom_range(2, GRID_MAX - 1), 100);

		// Fill the node store past capacity on a dense grid, idling ends late
		drain();
		write_grid($urandom_range(2, 6));
		k = 0;
		extra = 0;
		while (extra < 30) begin
			if (tracker.nodes_loaded >= MAX_NODES - 120)
				calm = 1'b1;
			else if (k % 64 == 0)
				calm = ($urandom_range(0, 2) == 0);
			send_item(random_item(1'b1));
			if (tracker.nodes_loaded == MAX_NODES) extra++;
			k++;
		end

		drain();
		repeat (40) @(posedge clk);
		tracker.close();
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/gcnc_pkg.sv
rtl/gcnc_ram.sv
rtl/gcnc_div.sv
rtl/gcnc_dp.sv
rtl/gcnc_ctrl.sv
rtl/grid_cell_neighbor_counter_unit.sv
tb/sv/tb_grid_cell_neighbor_counter_unit.sv
